### rtl/pve_pkg.sv
// Shared types, widths and codes of the polyphonic voice envelope block.
`timescale 1ns / 1ps
package pve_pkg;

   localparam int MAX_VOICES = 16;
   localparam int SLOT_W     = $clog2(MAX_VOICES);
   localparam int CNT_W      = $clog2(MAX_VOICES + 1);
   localparam int NOTE_W     = 7;
   localparam int ADV_W      = 12;
   localparam int ELAPSED_W  = 24;
   localparam int DUR_W      = 20;
   localparam int LVL_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   // action codes on the request side
   localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
   localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK    = 3'd4;

   typedef enum logic [2:0] {
      ST_LEVEL    = 3'd0,
      ST_NEW      = 3'd1,
      ST_RETRIG   = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_RELEASED = 3'd4,
      ST_NO_MATCH = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_TICK     = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      K_ATTACK  = 2'd0,
      K_DECAY   = 2'd1,
      K_SUSTAIN = 2'd2,
      K_RELEASE = 2'd3
   } env_kind_type;

   typedef struct packed {
      logic [DUR_W-1:0] attack;
      logic [DUR_W-1:0] decay;
      logic [LVL_W-1:0] sustain;
      logic [DUR_W-1:0] release_len;
      logic [LVL_W-1:0] peak;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [NOTE_W-1:0] note;
      logic [ADV_W-1:0]  advance;
   } cmd_type;

   typedef struct packed {
      logic [NOTE_W-1:0]    note;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 held;
      logic [ELAPSED_W-1:0] rel_start;
      logic [LVL_W-1:0]     rel_level;
   } voice_type;

   typedef struct packed {
      env_kind_type     kind;
      logic [LVL_W-1:0] factor;
      logic [DUR_W-1:0] mult;
      logic [LVL_W-1:0] sus;
      logic [DUR_W-1:0] divisor;
   } env_req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [NOTE_W-1:0] note;
      logic [LVL_W-1:0]  level;
      logic              last;
   } rsp_type;

endpackage

### rtl/pve_front.sv
// Front end: accepts request beats, classifies them and queues commands.
`timescale 1ns / 1ps
module pve_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [1:0]                   req_tuser,
   input  logic [23:0]                  req_tdata,
   output logic                         cmd_valid,
   output pve_pkg::cmd_type             cmd,
   input  logic                         cmd_pop
);
   import pve_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   cmd_type            q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     fill_ff, fill_in;
   logic               push, pop;
   cmd_type            incoming;

   assign req_tready = (fill_ff != PTR_W'(0) + (PTR_W+1)'(DEPTH));
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = q_ff[rd_ff];
   assign pop        = cmd_pop && cmd_valid;

   always_comb begin
      incoming.note    = req_tdata[NOTE_W-1:0];
      incoming.advance = req_tdata[NOTE_W +: ADV_W];
      push = req_tvalid && req_tready;
      unique case (req_tuser)
         ACT_NOTE_ON:  incoming.kind = CMD_NOTE_ON;
         ACT_NOTE_OFF: incoming.kind = CMD_NOTE_OFF;
         ACT_TICK:     incoming.kind = CMD_TICK;
         default: begin
            // unused action: taken and discarded
            incoming.kind = CMD_TICK;
            push = 1'b0;
         end
      endcase
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) q_ff[wr_ff] <= incoming;
   end

endmodule

### rtl/pve_env_unit.sv
// Envelope arithmetic: shift-add multiplier followed, except for sustain, by a restoring divider.
`timescale 1ns / 1ps
module pve_env_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  pve_pkg::env_req_type      req,
   output logic                      idle,
   output logic [pve_pkg::LVL_W-1:0] level
);
   import pve_pkg::*;

   localparam int X_W    = DUR_W + LVL_W + 1;
   localparam int PROD_W = X_W + LVL_W - 1;
   localparam int NUM_W  = DUR_W + LVL_W;
   localparam int STEP_W = $clog2(LVL_W);

   typedef enum logic [4:0] {
      U_IDLE = 5'b00001,
      U_PREP = 5'b00010,
      U_SUM  = 5'b00100,
      U_MUL  = 5'b01000,
      U_DIV  = 5'b10000
   } ustate_type;

   ustate_type          st_ff, st_in;
   env_req_type         req_ff, req_in;
   logic [X_W-2:0]      x1_ff, x1_in;
   logic [X_W-1:0]      x2_ff, x2_in;
   logic [PROD_W-1:0]   b_ff, b_in, prod_ff, prod_in, prod_n;
   logic [LVL_W-1:0]    f_ff, f_in, q_ff, q_in;
   logic [NUM_W-1:0]    rem_ff, rem_in, dsh_ff, dsh_in, num;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                ge;

   assign idle  = (st_ff == U_IDLE);
   assign level = q_ff;

   always_comb begin
      st_in   = st_ff;
      req_in  = req_ff;
      x1_in   = x1_ff;
      x2_in   = x2_ff;
      b_in    = b_ff;
      f_in    = f_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      prod_n  = prod_ff + (f_ff[0] ? b_ff : '0);
      num     = (req_ff.kind == K_ATTACK || req_ff.kind == K_RELEASE)
                ? prod_n[NUM_W-1:0] : prod_n[LVL_W +: NUM_W];
      ge      = (rem_ff >= dsh_ff);
      unique case (st_ff)
         U_IDLE: begin
            if (start) begin
               req_in  = req;
               f_in    = req.factor;
               b_in    = PROD_W'(req.mult);
               prod_in = '0;
               cnt_in  = '0;
               st_in   = (req.kind == K_DECAY) ? U_PREP : U_MUL;
            end
         end
         U_PREP: begin
            // decay numerator S*D + (1-S)*remaining, both terms at once
            x1_in = (X_W-1)'(req_ff.sus * req_ff.divisor);
            x2_in = X_W'(((LVL_W+1)'(1) << LVL_W) - (LVL_W+1)'(req_ff.sus)) * req_ff.mult;
            st_in = U_SUM;
         end
         U_SUM: begin
            b_in  = PROD_W'(x2_ff + X_W'(x1_ff));
            st_in = U_MUL;
         end
         U_MUL: begin
            prod_in = prod_n;
            b_in    = b_ff << 1;
            f_in    = f_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(LVL_W - 1)) begin
               cnt_in = '0;
               if (req_ff.kind == K_SUSTAIN) begin
                  q_in  = num[LVL_W-1:0];
                  st_in = U_IDLE;
               end else begin
                  rem_in = num;
                  dsh_in = NUM_W'(req_ff.divisor) << (LVL_W - 1);
                  st_in  = U_DIV;
               end
            end
         end
         U_DIV: begin
            // quotient is known to stay below 2^16
            if (ge) rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[LVL_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(LVL_W - 1)) st_in = U_IDLE;
         end
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= U_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      req_ff  <= req_in;
      x1_ff   <= x1_in;
      x2_ff   <= x2_in;
      b_ff    <= b_in;
      f_ff    <= f_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

endmodule

### rtl/pve_back.sv
// Back end: voice table, command sequencer and result register.
`timescale 1ns / 1ps
module pve_back (
   input  logic               clock,
   input  logic               reset,
   input  pve_pkg::cfg_type   cfg,
   input  logic               cmd_valid,
   input  pve_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pve_pkg::rsp_type   rsp
);
   import pve_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_OFF     = 6'b000010,
      S_OFFW    = 6'b000100,
      S_COMPACT = 6'b001000,
      S_LEVEL   = 6'b010000,
      S_LWAIT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic        zero;
      env_req_type req;
   } setup_type;

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [CNT_W-1:0]   count_ff, count_in, wj_ff, wj_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in, slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   voice_type          voice_ff [MAX_VOICES];
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr, rd_addr;
   voice_type          wr_data, rd_v;

   logic [MAX_VOICES-1:0] hit;
   logic                  any_hit;
   logic [SLOT_W-1:0]     hit_slot;
   logic                  out_free, last_idx;
   setup_type             su;
   logic                  unit_start, unit_idle;
   logic [LVL_W-1:0]      unit_level;
   logic [ELAPSED_W:0]    esum;
   logic [ELAPSED_W-1:0]  enew, erel;
   logic                  fin;

   function automatic setup_type level_setup(voice_type v, cfg_type c);
      setup_type          s;
      logic [ELAPSED_W-1:0] t, tma, e;
      logic [DUR_W:0]     ad;
      t  = v.elapsed;
      ad = {1'b0, c.attack} + {1'b0, c.decay};
      s.zero        = 1'b0;
      s.req.kind    = K_ATTACK;
      s.req.factor  = c.peak;
      s.req.mult    = t[DUR_W-1:0];
      s.req.sus     = c.sustain;
      s.req.divisor = c.attack;
      tma = t - ELAPSED_W'(c.attack);
      e   = (t >= v.rel_start) ? t - v.rel_start : '0;
      if (v.held) begin
         if (t < ELAPSED_W'(c.attack)) begin
            s.req.kind = K_ATTACK;
         end else if (t < ELAPSED_W'(ad)) begin
            s.req.kind    = K_DECAY;
            s.req.divisor = c.decay;
            s.req.mult    = c.decay - tma[DUR_W-1:0];
         end else begin
            s.req.kind = K_SUSTAIN;
            s.req.mult = DUR_W'(c.sustain);
         end
      end else if (e >= ELAPSED_W'(c.release_len)) begin
         s.zero = 1'b1;
      end else begin
         s.req.kind    = K_RELEASE;
         s.req.factor  = v.rel_level;
         s.req.divisor = c.release_len;
         s.req.mult    = c.release_len - e[DUR_W-1:0];
      end
      return s;
   endfunction

   pve_env_unit u_env (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .req   (su.req),
      .idle  (unit_idle),
      .level (unit_level)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_addr   = (state_ff == S_OFF || state_ff == S_OFFW) ? slot_ff : idx_ff;
   assign rd_v      = voice_ff[rd_addr];
   assign su        = level_setup(rd_v, cfg);
   assign last_idx  = ({1'b0, idx_ff} == count_ff - 1'b1);

   // notes are unique in the table, so at most one slot hits
   always_comb begin
      any_hit  = 1'b0;
      hit_slot = '0;
      for (int k = 0; k < MAX_VOICES; k++) begin
         hit[k] = (CNT_W'(k) < count_ff) && (voice_ff[k].note == cmd.note);
      end
      for (int k = MAX_VOICES - 1; k >= 0; k--) begin
         if (hit[k]) begin
            any_hit  = 1'b1;
            hit_slot = SLOT_W'(k);
         end
      end
   end

   // tick advance with saturation, and the end-of-release test
   always_comb begin
      esum = {1'b0, rd_v.elapsed} + (ELAPSED_W+1)'(cur_ff.advance);
      enew = esum[ELAPSED_W] ? ELAPSED_MAX : esum[ELAPSED_W-1:0];
      erel = (enew >= rd_v.rel_start) ? enew - rd_v.rel_start : '0;
      fin  = !rd_v.held && (enew == ELAPSED_MAX || erel >= ELAPSED_W'(cfg.release_len));
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      wj_in        = wj_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      unit_start   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = rd_addr;
      wr_data      = rd_v;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop    = 1'b1;
               cur_in     = cmd;
               rsp_in     = '{status: ST_LEVEL, slot: '0, note: cmd.note,
                              level: '0, last: 1'b1};
               wr_data    = '{note: cmd.note, elapsed: '0, held: 1'b1,
                              rel_start: '0, rel_level: '0};
               unique case (cmd.kind)
                  CMD_NOTE_ON: begin
                     rsp_valid_in = 1'b1;
                     if (any_hit) begin
                        wr_en         = 1'b1;
                        wr_addr       = hit_slot;
                        rsp_in.status = ST_RETRIG;
                        rsp_in.slot   = hit_slot;
                     end else if (count_ff == CNT_W'(MAX_VOICES)) begin
                        rsp_in.status = ST_DROPPED;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[SLOT_W-1:0];
                        rsp_in.status = ST_NEW;
                        rsp_in.slot   = count_ff[SLOT_W-1:0];
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  CMD_NOTE_OFF: begin
                     if (any_hit) begin
                        slot_in  = hit_slot;
                        state_in = S_OFF;
                     end else begin
                        rsp_in.status = ST_NO_MATCH;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        wj_in    = '0;
                        state_in = S_COMPACT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_OFF: begin
            if (su.zero) begin
               if (out_free) begin
                  wr_en             = 1'b1;
                  wr_data.held      = 1'b0;
                  wr_data.rel_start = rd_v.elapsed;
                  wr_data.rel_level = '0;
                  rsp_in = '{status: ST_RELEASED, slot: slot_ff, note: rd_v.note,
                             level: '0, last: 1'b1};
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               unit_start = 1'b1;
               state_in   = S_OFFW;
            end
         end
         S_OFFW: begin
            if (unit_idle && out_free) begin
               wr_en             = 1'b1;
               wr_data.held      = 1'b0;
               wr_data.rel_start = rd_v.elapsed;
               wr_data.rel_level = unit_level;
               rsp_in = '{status: ST_RELEASED, slot: slot_ff, note: rd_v.note,
                          level: '0, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_COMPACT: begin
            // survivors slide down to slot wj, order kept
            wr_addr         = wj_ff[SLOT_W-1:0];
            wr_data.elapsed = enew;
            if (!fin) begin
               wr_en = 1'b1;
               wj_in = wj_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               count_in = wj_in;
               idx_in   = '0;
               state_in = (wj_in == '0) ? S_IDLE : S_LEVEL;
            end
         end
         S_LEVEL: begin
            if (su.zero) begin
               if (out_free) begin
                  rsp_in = '{status: ST_LEVEL, slot: idx_ff, note: rd_v.note,
                             level: '0, last: last_idx};
                  rsp_valid_in = 1'b1;
                  idx_in       = idx_ff + 1'b1;
                  state_in     = last_idx ? S_IDLE : S_LEVEL;
               end
            end else begin
               unit_start = 1'b1;
               state_in   = S_LWAIT;
            end
         end
         S_LWAIT: begin
            if (unit_idle && out_free) begin
               rsp_in = '{status: ST_LEVEL, slot: idx_ff, note: rd_v.note,
                          level: unit_level, last: last_idx};
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               state_in     = last_idx ? S_IDLE : S_LEVEL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff  <= cur_in;
      wj_ff   <= wj_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
      if (wr_en) voice_ff[wr_addr] <= wr_data;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VOICES))
      else $error("voice count above table size");

   a_unit_free: assert property (@(posedge clock) disable iff (reset)
      unit_start |-> unit_idle)
      else $error("envelope unit started while busy");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMPACT) |-> (wj_ff <= {1'b0, idx_ff}))
      else $error("compaction write slot passed read slot");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE) && out_free)
      else $error("command taken while sequencer busy");
`endif

endmodule

### rtl/poly_voice_adsr_envelope.sv
// Top level: configuration registers, command front end and voice back end.
`timescale 1ns / 1ps
// Polyphonic voice table with ADSR envelopes. Request beats carry a note-on,
// note-off or tick; each note event returns one beat, a tick returns one
// level beat per surviving voice (none with an empty table), tlast on the
// final one. A short command queue lets requests arrive while the sequencer
// works. A note-on or an unmatched note-off is handled by the sequencer alone;
// a note-off on a voice whose level must be computed first runs that level
// through the envelope unit. A tick makes an advance and compaction pass
// over the active voices, then computes each surviving voice's level in
// turn through the shared envelope unit, a 16-step shift-add multiplier
// followed, except in sustain, by a 16-step restoring divider. The user
// must write registers through csr_we/csr_index/csr_wdata only while the
// block is idle; the block itself does not enforce this. Unknown indexes
// are ignored.
module poly_voice_adsr_envelope (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [1:0]                        req_tuser,  // action
   input  logic [23:0]                       req_tdata,  // note[6:0], advance[18:7]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2:0]                        rsp_tuser,  // status
   output logic [31:0]                       rsp_tdata,  // voice_slot[3:0], voice_note[10:4],
                                                         // level[26:11]
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [pve_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pve_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pve_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cmd_valid, cmd_pop;
   cmd_type  cmd;
   rsp_type  rsp;

   // register file, values masked to field width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ATTACK:  cfg_in.attack      = csr_wdata[DUR_W-1:0];
            REG_DECAY:   cfg_in.decay       = csr_wdata[DUR_W-1:0];
            REG_SUSTAIN: cfg_in.sustain     = csr_wdata[LVL_W-1:0];
            REG_RELEASE: cfg_in.release_len = csr_wdata[DUR_W-1:0];
            REG_PEAK:    cfg_in.peak        = csr_wdata[LVL_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack      <= DUR_W'(2400);
         cfg_ff.decay       <= DUR_W'(2400);
         cfg_ff.sustain     <= LVL_W'(52429);
         cfg_ff.release_len <= DUR_W'(4800);
         cfg_ff.peak        <= LVL_W'(13107);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pve_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   pve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {5'b0, rsp.level, rsp.note, rsp.slot};
   assign rsp_tlast = rsp.last;

endmodule

### verif/tb.sv
// Self-checking testbench for the polyphonic voice ADSR envelope block.
`timescale 1ns / 1ps
module tb;
   import pve_pkg::*;

   localparam logic [1:0] ACT_NONE  = 2'd3;   // unused action code, block ignores it
   localparam int         CLK_HALF  = 2;
   localparam int         DRAIN_GAP = 800;
   localparam int         LIMIT     = 1500000;
   localparam logic [23:0] SAT      = 24'hFFFFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser = '0;
   logic [23:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [2:0]            rsp_tuser;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   poly_voice_adsr_envelope dut (.*);

   always #(CLK_HALF) clock = ~clock;

   // envelope settings as the block should hold them
   longint unsigned env_attack, env_decay, env_sustain, env_release, env_peak;

   // voice table copy
   bit [6:0]  vt_note    [MAX_VOICES];
   bit [23:0] vt_elapsed [MAX_VOICES];
   bit        vt_held    [MAX_VOICES];
   bit [23:0] vt_rel_at  [MAX_VOICES];
   bit [15:0] vt_rel_lvl [MAX_VOICES];
   int        vt_count;

   rsp_type   pending_rsp[$];
   int        errors;
   int        cycles;
   int        hold_len;      // long receiver hold-off, counted down below
   bit        steady;        // sender offers back to back when set
   int        burst_left;

   // ---------------------------------------------------------------- predictor
   function automatic bit [15:0] held_env(longint unsigned t);
      longint unsigned rem;
      if (t < env_attack)
         return 16'(env_peak * t / env_attack);
      if (t < env_attack + env_decay) begin
         rem = env_decay - (t - env_attack);
         return 16'(env_peak * (env_sustain * env_decay + (65536 - env_sustain) * rem)
                    / (65536 * env_decay));
      end
      return 16'((env_peak * env_sustain) >> 16);
   endfunction

   function automatic longint unsigned rel_elapsed(int i);
      return (vt_elapsed[i] >= vt_rel_at[i]) ? vt_elapsed[i] - vt_rel_at[i] : 0;
   endfunction

   function automatic bit [15:0] voice_env(int i);
      longint unsigned e;
      if (vt_held[i])
         return held_env(vt_elapsed[i]);
      e = rel_elapsed(i);
      if (e >= env_release)
         return 16'd0;
      return 16'(vt_rel_lvl[i] * (env_release - e) / env_release);
   endfunction

   function automatic void expect_beat(status_type st, int slot, bit [6:0] nt,
                                       bit [15:0] lvl, bit lst);
      rsp_type r;
      r.status = st;
      r.slot   = SLOT_W'(slot);
      r.note   = nt;
      r.level  = lvl;
      r.last   = lst;
      pending_rsp.push_back(r);
   endfunction

   // updates the voice table for one accepted beat and queues its results
   function automatic void track_voices(bit [1:0] act, bit [6:0] nt, bit [11:0] adv);
      int i, j, n, slot;
      longint unsigned e;
      case (act)
         ACT_NOTE_ON: begin
            slot = -1;
            for (i = 0; i < vt_count; i++)
               if (slot < 0 && vt_note[i] == nt) slot = i;
            if (slot >= 0) begin
               expect_beat(ST_RETRIG, slot, nt, 0, 1'b1);
            end else if (vt_count >= MAX_VOICES) begin
               expect_beat(ST_DROPPED, 0, nt, 0, 1'b1);
               return;
            end else begin
               slot = vt_count++;
               vt_rel_at[slot]  = 0;
               vt_rel_lvl[slot] = 0;
               expect_beat(ST_NEW, slot, nt, 0, 1'b1);
            end
            vt_note[slot]    = nt;
            vt_elapsed[slot] = 0;
            vt_held[slot]    = 1'b1;
         end
         ACT_NOTE_OFF: begin
            n = 0;
            for (i = 0; i < vt_count; i++) begin
               if (vt_note[i] != nt) continue;
               vt_rel_lvl[i] = voice_env(i);
               vt_rel_at[i]  = vt_elapsed[i];
               vt_held[i]    = 1'b0;
               expect_beat(ST_RELEASED, i, nt, 0, 1'b0);
               n++;
            end
            if (n == 0) expect_beat(ST_NO_MATCH, 0, nt, 0, 1'b0);
            pending_rsp[$].last = 1'b1;
         end
         ACT_TICK: begin
            for (i = 0; i < vt_count; i++) begin
               e = vt_elapsed[i] + adv;
               vt_elapsed[i] = (e > SAT) ? SAT : 24'(e);
            end
            j = 0;
            for (i = 0; i < vt_count; i++) begin
               // finished release: gone, later voices close up
               if (!vt_held[i] && (vt_elapsed[i] == SAT || rel_elapsed(i) >= env_release))
                  continue;
               vt_note[j]    = vt_note[i];
               vt_elapsed[j] = vt_elapsed[i];
               vt_held[j]    = vt_held[i];
               vt_rel_at[j]  = vt_rel_at[i];
               vt_rel_lvl[j] = vt_rel_lvl[i];
               j++;
            end
            vt_count = j;
            for (i = 0; i < vt_count; i++)
               expect_beat(ST_LEVEL, i, vt_note[i], voice_env(i), i == vt_count - 1);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- driving
   // One request beat; predicts at acceptance, then maybe opens a gap.
   task automatic send_beat(bit [1:0] act, bit [6:0] nt, bit [11:0] adv);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, adv, nt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_voices(act, nt, adv);
      if (steady) return;
      if (--burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // sender pause until every expected beat is back, plus the busy margin
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_env(int a, int d, int s, int r, int p);
      bit [CSR_IDX_W-1:0] idx [6];
      int                 val [6];
      idx = '{REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE, REG_PEAK, 3'd5};
      val = '{a, d, s, r, p, $urandom};   // last one: unknown index, ignored
      for (int k = 0; k < 6; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= CSR_DATA_W'(val[k]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      env_attack  = a & 20'hFFFFF;
      env_decay   = d & 20'hFFFFF;
      env_sustain = s & 16'hFFFF;
      env_release = r & 20'hFFFFF;
      env_peak    = p & 16'hFFFF;
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report(string what, longint got, longint want);
      errors++;
      $display("tb: mismatch %s got %0d want %0d (cycle %0d)", what, got, want, cycles);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected beat, status", rsp_tuser, -1);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser != want.status)      report("status", rsp_tuser, want.status);
            if (rsp_tdata[3:0] != want.slot)   report("slot", rsp_tdata[3:0], want.slot);
            if (rsp_tdata[10:4] != want.note)  report("note", rsp_tdata[10:4], want.note);
            if (rsp_tdata[26:11] != want.level)
               report("level", rsp_tdata[26:11], want.level);
            if (rsp_tlast != want.last)        report("tlast", rsp_tlast, want.last);
         end
      end
   end

   // receiver: stall-free stretches alternate with random stalls; a long
   // hold-off overrides both while hold_len runs down
   always @(posedge clock) begin
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len   <= hold_len - 1;
      end else if ((cycles / 300) % 3 == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 6);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // Field extremes, every action, retrigger, re-release, no match, empty tick.
   task automatic test_directed();
      send_beat(ACT_TICK, 7'd0, 12'd4095);      // empty table: nothing back
      send_beat(ACT_NONE, 7'd127, 12'd4095);    // ignored action
      send_beat(ACT_NOTE_OFF, 7'd5, 12'd0);     // no voice holds it
      send_beat(ACT_NOTE_ON, 7'd0, 12'd0);
      send_beat(ACT_NOTE_ON, 7'd127, 12'd4095);
      send_beat(ACT_TICK, 7'd127, 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd2000);      // attack
      send_beat(ACT_NOTE_ON, 7'd0, 12'd0);      // retrigger
      send_beat(ACT_TICK, 7'd0, 12'd4095);      // decay
      send_beat(ACT_NOTE_OFF, 7'd127, 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd1000);
      send_beat(ACT_NOTE_OFF, 7'd127, 12'd0);   // release again from present level
      send_beat(ACT_NOTE_ON, 7'd127, 12'd0);    // retrigger a released voice
      send_beat(ACT_TICK, 7'd0, 12'd4095);      // sustain
      send_beat(ACT_NOTE_OFF, 7'd0, 12'd0);
      send_beat(ACT_NOTE_OFF, 7'd127, 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd4095);
      send_beat(ACT_TICK, 7'd0, 12'd4095);      // releases end, table empties
      drain();
   endtask

   // Sixteen voices, then a dropped note; a long hold-off backs the block up.
   task automatic test_full_table();
      steady = 1'b1;
      hold_len = 600;
      for (int k = 0; k < MAX_VOICES; k++)
         send_beat(ACT_NOTE_ON, 7'(k * 8 + 3), 12'd0);
      send_beat(ACT_NOTE_ON, 7'd100, 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd50);
      send_beat(ACT_NOTE_OFF, 7'd19, 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd4095);
      steady = 1'b0;
      for (int k = 0; k < MAX_VOICES; k++)
         send_beat(ACT_NOTE_OFF, 7'(k * 8 + 3), 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd4095);
      drain();
   endtask

   // Longest durations: a held voice deep in its attack, released from there.
   task automatic test_long_env();
      send_beat(ACT_NOTE_ON, 7'd64, 12'd0);
      for (int k = 0; k < 4; k++)
         send_beat(ACT_TICK, 7'd0, 12'd4095);
      send_beat(ACT_NOTE_OFF, 7'd64, 12'd0);
      send_beat(ACT_TICK, 7'd0, 12'd1);
      drain();
   endtask

   // Mostly note traffic on a small pool of notes, ticks mostly with small advances.
   task automatic test_random(int beats);
      int        pick;
      bit [6:0]  nt;
      bit [11:0] adv;
      for (int k = 0; k < beats; k++) begin
         if (k == beats / 2) hold_len = 400;
         pick = $urandom_range(0, 99);
         nt   = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 19));
         adv  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
         if (pick < 38)      send_beat(ACT_NOTE_ON, nt, adv);
         else if (pick < 62) send_beat(ACT_NOTE_OFF, nt, adv);
         else if (pick < 96) send_beat(ACT_TICK, nt, adv);
         else                send_beat(ACT_NONE, nt, adv);
      end
      drain();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      hold_len = 0;
      steady = 1'b0;
      burst_left = 4;
      vt_count = 0;
      env_attack = 2400; env_decay = 2400; env_sustain = 52429;
      env_release = 4800; env_peak = 13107;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();          // reset settings
      test_full_table();
      write_env(1, 1, 65535, 1, 65535);
      test_directed();
      test_random(12);
      write_env(1048575, 1048575, 0, 1048575, 65535);
      test_long_env();
      write_env(300, 200, 30000, 500, 0);
      test_random(8);
      write_env($urandom_range(1, 800), $urandom_range(1, 800), $urandom_range(0, 65535),
                $urandom_range(1, 1200), $urandom_range(0, 65535));
      test_random(12);

      if (errors == 0) $display("tb: done, clean");
      else             $display("tb: done, errors");
      $finish;
   end

endmodule

### sim.f
rtl/pve_pkg.sv
rtl/pve_front.sv
rtl/pve_env_unit.sv
rtl/pve_back.sv
rtl/poly_voice_adsr_envelope.sv
verif/tb.sv
